### src/cll_pkg.sv
// ---------------------------------------------------------------------------
// cll_pkg: shared types and constants for the circular linked list
// Command codes, payload structs, register map and node store write enables.
// ---------------------------------------------------------------------------
package cll_pkg;

    // default size of the node store
    localparam int SLOTS_DEFAULT = 128;

    // field widths fixed by the interface
    localparam int VALUE_W = 32;
    localparam int TOTAL_W = 8;
    localparam int CAP_W   = 8;

    // configuration port
    localparam int         DATA_W       = 32;
    localparam int         ADDR_W       = 2;
    localparam logic [ADDR_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CAP_W-1:0]  CAPACITY_RESET = 8'd100;

    // command codes
    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    // one command transaction
    typedef struct packed {
        cmd_t                      cmd;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    // one result transaction
    typedef struct packed {
        logic                      ok;
        logic signed [VALUE_W-1:0] removed_value;
        logic [TOTAL_W-1:0]        element_total;
    } result_t;

    // write enables of the node store, one per memory
    typedef struct packed {
        logic data_we;
        logic fwd_we;
        logic bwd_we;
    } node_wen_t;

endpackage

### src/cll_node_store.sv
// ---------------------------------------------------------------------------
// cll_node_store: node memories of the linked list
// Data, forward link and backward link arrays, each with its own write
// port and a shared read address with registered read data.
// ---------------------------------------------------------------------------
module cll_node_store #(
    parameter int SLOTS = cll_pkg::SLOTS_DEFAULT,
    localparam int SW   = $clog2(SLOTS)
) (
    input  logic                         clk,
    input  logic [SW-1:0]                rd_addr,
    input  cll_pkg::node_wen_t           wen,
    input  logic [SW-1:0]                wr_addr_data,
    input  logic [SW-1:0]                wr_addr_fwd,
    input  logic [SW-1:0]                wr_addr_bwd,
    input  logic [cll_pkg::VALUE_W-1:0]  wr_data,
    input  logic [SW-1:0]                wr_fwd,
    input  logic [SW-1:0]                wr_bwd,
    output logic [cll_pkg::VALUE_W-1:0]  rd_data,
    output logic [SW-1:0]                rd_fwd,
    output logic [SW-1:0]                rd_bwd
);

    logic [cll_pkg::VALUE_W-1:0] data_mem [SLOTS];
    logic [SW-1:0]               fwd_mem  [SLOTS];
    logic [SW-1:0]               bwd_mem  [SLOTS];

    // value memory
    always_ff @(posedge clk)
    begin
        if (wen.data_we)
        begin
            data_mem[wr_addr_data] <= wr_data;
        end
        rd_data <= data_mem[rd_addr];
    end

    // forward link memory
    always_ff @(posedge clk)
    begin
        if (wen.fwd_we)
        begin
            fwd_mem[wr_addr_fwd] <= wr_fwd;
        end
        rd_fwd <= fwd_mem[rd_addr];
    end

    // backward link memory
    always_ff @(posedge clk)
    begin
        if (wen.bwd_we)
        begin
            bwd_mem[wr_addr_bwd] <= wr_bwd;
        end
        rd_bwd <= bwd_mem[rd_addr];
    end

endmodule

### src/circular_list_head_insert_remove_search.sv
// ---------------------------------------------------------------------------
// circular_list_head_insert_remove_search: circular doubly linked list
// Insert at head, remove from head, search and clear over a node store,
// with freed slots recycled through a free-slot stack.
// ---------------------------------------------------------------------------
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------
//  command   | start, busy             | request (cmd, value)
//  result    | done (one-cycle strobe) | result (ok, removed_value, total)
//  config    | psel/penable/pwrite     | paddr, pwdata, prdata (capacity)
//
//  A command is taken when start is high and busy is low; busy then stays
//  high until the result strobe. Insert into a non-empty list adds a link
//  step (the link fix-up needs a second write to each link memory); remove
//  and clear finish in the execute step; search walks the nodes, at most the
//  element count, one node per cycle through the node store read port.
//  done pulses in the first cycle in which busy is low; the receiver cannot
//  stall it. No clearing pass after reset: the store is only read where
//  written.
//
module circular_list_head_insert_remove_search #(
    parameter int SLOTS = cll_pkg::SLOTS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  cll_pkg::request_t            request,
    // result channel
    output logic                         done,
    output cll_pkg::result_t             result,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cll_pkg::ADDR_W-1:0]   paddr,
    input  logic [cll_pkg::DATA_W-1:0]   pwdata,
    output logic [cll_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int LW = (CW > cll_pkg::CAP_W) ? CW : cll_pkg::CAP_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_WALK
    } state_t;

    state_t                        state_reg;
    cll_pkg::cmd_t                 cmd_reg;
    logic [cll_pkg::VALUE_W-1:0]   value_reg;
    logic [SW-1:0]                 slot_reg;
    logic [SW-1:0]                 last_reg;
    logic [CW-1:0]                 walk_reg;
    logic [SW-1:0]                 head_reg;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 fresh_reg;
    logic [CW-1:0]                 depth_reg;
    logic [cll_pkg::CAP_W-1:0]     capacity_reg;
    logic                          done_reg;
    cll_pkg::result_t              result_reg;

    // node store ports
    logic [SW-1:0]                 rd_addr;
    cll_pkg::node_wen_t            wen;
    logic [SW-1:0]                 wr_addr_fwd;
    logic [SW-1:0]                 wr_addr_bwd;
    logic [SW-1:0]                 wr_fwd;
    logic [SW-1:0]                 wr_bwd;
    logic [cll_pkg::VALUE_W-1:0]   rd_data;
    logic [SW-1:0]                 rd_fwd;
    logic [SW-1:0]                 rd_bwd;

    // free-slot stack
    logic [SW-1:0]                 free_stack [SLOTS];
    logic [SW-1:0]                 fs_rd;
    logic [CW-1:0]                 depth_m1;
    logic                          fs_we;

    // allocator and decision terms
    logic                          cfg_write;
    logic                          use_free;
    logic                          slot_avail;
    logic                          under_limit;
    logic                          can_insert;
    logic [SW-1:0]                 slot_pick;
    logic [CW-1:0]                 count_inc;
    logic [CW-1:0]                 count_dec;
    logic                          list_empty;
    logic                          value_match;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr == cll_pkg::REG_CAPACITY) ?
                       cll_pkg::DATA_W'(capacity_reg) : '0;

    // allocator view
    assign depth_m1    = depth_reg - CW'(1);
    assign use_free    = (depth_reg != CW'(0));
    assign slot_avail  = use_free || (fresh_reg < CW'(SLOTS));
    assign under_limit = (LW'(count_reg) < LW'(capacity_reg)) && (count_reg < CW'(SLOTS));
    assign can_insert  = under_limit && slot_avail;
    assign slot_pick   = use_free ? fs_rd : fresh_reg[SW-1:0];
    assign count_inc   = count_reg + CW'(1);
    assign count_dec   = count_reg - CW'(1);
    assign list_empty  = (count_reg == CW'(0));

    // shared compare unit for the search walk
    assign value_match = (rd_data == value_reg);

    // read address: head at start, then follow forward links
    assign rd_addr = (state_reg == S_WALK) ? rd_fwd : head_reg;

    // node store and free stack write control
    always_comb
    begin
        wen         = '0;
        wr_addr_fwd = slot_pick;
        wr_addr_bwd = slot_pick;
        wr_fwd      = slot_pick;
        wr_bwd      = slot_pick;
        fs_we       = 1'b0;
        unique case (state_reg)
            S_EXEC:
            begin
                if (cmd_reg == cll_pkg::CMD_INSERT && can_insert)
                begin
                    wen.data_we = 1'b1;
                    wen.fwd_we  = 1'b1;
                    wen.bwd_we  = 1'b1;
                    if (!list_empty)
                    begin
                        wr_fwd = head_reg;
                        wr_bwd = rd_bwd;
                    end
                end
                else if (cmd_reg == cll_pkg::CMD_REMOVE && !list_empty)
                begin
                    fs_we = (depth_reg < CW'(SLOTS));
                    if (count_reg > CW'(1))
                    begin
                        wen.fwd_we  = 1'b1;
                        wen.bwd_we  = 1'b1;
                        wr_addr_fwd = rd_bwd;
                        wr_fwd      = rd_fwd;
                        wr_addr_bwd = rd_fwd;
                        wr_bwd      = rd_bwd;
                    end
                end
            end
            S_LINK:
            begin
                wen.fwd_we  = 1'b1;
                wen.bwd_we  = 1'b1;
                wr_addr_fwd = last_reg;
                wr_fwd      = slot_reg;
                wr_addr_bwd = head_reg;
                wr_bwd      = slot_reg;
            end
            default:
            begin
                wen = '0;
            end
        endcase
    end

    cll_node_store #(
        .SLOTS (SLOTS)
    ) u_store (
        .clk          (clk),
        .rd_addr      (rd_addr),
        .wen          (wen),
        .wr_addr_data (slot_pick),
        .wr_addr_fwd  (wr_addr_fwd),
        .wr_addr_bwd  (wr_addr_bwd),
        .wr_data      (value_reg),
        .wr_fwd       (wr_fwd),
        .wr_bwd       (wr_bwd),
        .rd_data      (rd_data),
        .rd_fwd       (rd_fwd),
        .rd_bwd       (rd_bwd)
    );

    // free-slot stack memory, top entry read every cycle
    always_ff @(posedge clk)
    begin
        if (fs_we)
        begin
            free_stack[depth_reg[SW-1:0]] <= head_reg;
        end
        fs_rd <= free_stack[depth_m1[SW-1:0]];
    end

    // sequencer, list state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            fresh_reg    <= '0;
            depth_reg    <= '0;
            walk_reg     <= '0;
            capacity_reg <= cll_pkg::CAPACITY_RESET;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_write && paddr == cll_pkg::REG_CAPACITY)
            begin
                capacity_reg <= pwdata[cll_pkg::CAP_W-1:0];
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cmd_reg   <= request.cmd;
                        value_reg <= request.value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    unique case (cmd_reg)
                        cll_pkg::CMD_INSERT:
                        begin
                            if (can_insert)
                            begin
                                if (use_free)
                                begin
                                    depth_reg <= depth_m1;
                                end
                                else
                                begin
                                    fresh_reg <= fresh_reg + CW'(1);
                                end
                                if (list_empty)
                                begin
                                    head_reg                 <= slot_pick;
                                    count_reg                <= count_inc;
                                    done_reg                 <= 1'b1;
                                    result_reg.ok            <= 1'b1;
                                    result_reg.removed_value <= '0;
                                    result_reg.element_total <= cll_pkg::TOTAL_W'(count_inc);
                                    state_reg                <= S_IDLE;
                                end
                                else
                                begin
                                    slot_reg  <= slot_pick;
                                    last_reg  <= rd_bwd;
                                    state_reg <= S_LINK;
                                end
                            end
                            else
                            begin
                                done_reg                 <= 1'b1;
                                result_reg.ok            <= 1'b0;
                                result_reg.removed_value <= '0;
                                result_reg.element_total <= cll_pkg::TOTAL_W'(count_reg);
                                state_reg                <= S_IDLE;
                            end
                        end
                        cll_pkg::CMD_REMOVE:
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                            if (!list_empty)
                            begin
                                if (count_reg > CW'(1))
                                begin
                                    head_reg <= rd_fwd;
                                end
                                if (depth_reg < CW'(SLOTS))
                                begin
                                    depth_reg <= depth_reg + CW'(1);
                                end
                                count_reg                <= count_dec;
                                result_reg.ok            <= 1'b1;
                                result_reg.removed_value <= rd_data;
                                result_reg.element_total <= cll_pkg::TOTAL_W'(count_dec);
                            end
                            else
                            begin
                                result_reg.ok            <= 1'b0;
                                result_reg.removed_value <= '0;
                                result_reg.element_total <= cll_pkg::TOTAL_W'(count_reg);
                            end
                        end
                        cll_pkg::CMD_SEARCH:
                        begin
                            if (list_empty)
                            begin
                                done_reg                 <= 1'b1;
                                result_reg.ok            <= 1'b0;
                                result_reg.removed_value <= '0;
                                result_reg.element_total <= cll_pkg::TOTAL_W'(count_reg);
                                state_reg                <= S_IDLE;
                            end
                            else
                            begin
                                walk_reg  <= '0;
                                state_reg <= S_WALK;
                            end
                        end
                        cll_pkg::CMD_CLEAR:
                        begin
                            head_reg                 <= '0;
                            count_reg                <= '0;
                            fresh_reg                <= '0;
                            depth_reg                <= '0;
                            done_reg                 <= 1'b1;
                            result_reg.ok            <= 1'b1;
                            result_reg.removed_value <= '0;
                            result_reg.element_total <= '0;
                            state_reg                <= S_IDLE;
                        end
                        default:
                        begin
                            state_reg <= S_IDLE;
                        end
                    endcase
                end
                S_LINK:
                begin
                    // second half of a head insert into a non-empty list
                    head_reg                 <= slot_reg;
                    count_reg                <= count_inc;
                    done_reg                 <= 1'b1;
                    result_reg.ok            <= 1'b1;
                    result_reg.removed_value <= '0;
                    result_reg.element_total <= cll_pkg::TOTAL_W'(count_inc);
                    state_reg                <= S_IDLE;
                end
                S_WALK:
                begin
                    // one node compared per cycle
                    if (value_match || walk_reg == count_dec)
                    begin
                        done_reg                 <= 1'b1;
                        result_reg.ok            <= value_match;
                        result_reg.removed_value <= '0;
                        result_reg.element_total <= cll_pkg::TOTAL_W'(count_reg);
                        state_reg                <= S_IDLE;
                    end
                    else
                    begin
                        walk_reg <= walk_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // a result strobe always closes a busy period
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
    else $error("result strobe without a transaction in flight");

    // an accepted command makes the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

    // every slot handed out is either in the list or on the free stack;
    // in the link step the count is still one behind the allocator
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_LINK) |->
            (({1'b0, count_reg} + {1'b0, depth_reg}) == {1'b0, fresh_reg}))
    else $error("slot allocator lost track of a slot");

    // element count never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(SLOTS))
    else $error("element count beyond store size");

    // a removed value is only reported on success
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.removed_value != '0) |-> result.ok)
    else $error("removed value reported on a failed command");

endmodule

### dv/circular_list_head_insert_remove_search_test.sv
// ---------------------------------------------------------------------------
// circular_list_head_insert_remove_search_test: self-checking testbench
// Drives insert, remove, search and clear transactions into the list under
// several capacity settings. A scoreboard keeps its own copy of the node
// store, links and free-slot stack, and checks every result strobe in order.
// ---------------------------------------------------------------------------
module circular_list_head_insert_remove_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    // list shadow and in-order result checker
    class list_scoreboard;
        logic [cll_pkg::CAP_W-1:0]   capacity;
        logic [cll_pkg::VALUE_W-1:0] node_value [cll_pkg::SLOTS_DEFAULT];
        logic [6:0]                  node_next  [cll_pkg::SLOTS_DEFAULT];
        logic [6:0]                  node_prev  [cll_pkg::SLOTS_DEFAULT];
        logic [6:0]                  free_slots [cll_pkg::SLOTS_DEFAULT];
        logic [6:0]                  head;
        int                          count;
        int                          fresh;
        int                          free_top;
        cll_pkg::result_t            awaited_results [$];
        int                          failures;
        int                          checked;
        int                          n_insert;
        int                          n_full;
        int                          n_remove;
        int                          n_empty_remove;
        int                          n_search;
        int                          n_hit;
        int                          n_clear;

        function new();
            capacity       = cll_pkg::CAPACITY_RESET;
            head           = '0;
            count          = 0;
            fresh          = 0;
            free_top       = 0;
            failures       = 0;
            checked        = 0;
            n_insert       = 0;
            n_full         = 0;
            n_remove       = 0;
            n_empty_remove = 0;
            n_search       = 0;
            n_hit          = 0;
            n_clear        = 0;
        endfunction

        // value held idx nodes forward of the head, idx below count
        function logic [cll_pkg::VALUE_W-1:0] stored_value(int idx);
            logic [6:0] cur;
            cur = head;
            for (int k = 0; k < idx; k++)
                cur = node_next[cur];
            return node_value[cur];
        endfunction

        // apply one accepted command transaction and queue its result
        function void note_command(cll_pkg::request_t rq);
            cll_pkg::result_t r;
            int               lim;
            logic [6:0]       s;
            logic [6:0]       nx;
            logic [6:0]       pv;
            logic [6:0]       cur;
            bit               got;
            r   = '0;
            lim = (capacity < cll_pkg::SLOTS_DEFAULT) ? int'(capacity) :
                  cll_pkg::SLOTS_DEFAULT;
            s   = '0;
            case (rq.cmd)
                cll_pkg::CMD_INSERT:
                begin
                    n_insert++;
                    got = 1'b0;
                    // free stack first, then slots never used
                    if (count < lim)
                    begin
                        got = 1'b1;
                        if (free_top > 0)
                        begin
                            free_top--;
                            s = free_slots[free_top];
                        end
                        else if (fresh < cll_pkg::SLOTS_DEFAULT)
                        begin
                            s = 7'(fresh);
                            fresh++;
                        end
                        else
                            got = 1'b0;
                    end
                    if (got)
                    begin
                        node_value[s] = rq.value;
                        if (count == 0)
                        begin
                            node_next[s] = s;
                            node_prev[s] = s;
                        end
                        else
                        begin
                            pv              = node_prev[head];
                            node_next[s]    = head;
                            node_prev[s]    = pv;
                            node_next[pv]   = s;
                            node_prev[head] = s;
                        end
                        head = s;
                        count++;
                        r.ok = 1'b1;
                    end
                    else
                        n_full++;
                end
                cll_pkg::CMD_REMOVE:
                begin
                    n_remove++;
                    if (count > 0)
                    begin
                        r.removed_value = node_value[head];
                        s = head;
                        // unlink the head and move it forward
                        if (count > 1)
                        begin
                            nx            = node_next[s];
                            pv            = node_prev[s];
                            node_next[pv] = nx;
                            node_prev[nx] = pv;
                            head          = nx;
                        end
                        if (free_top < cll_pkg::SLOTS_DEFAULT)
                        begin
                            free_slots[free_top] = s;
                            free_top++;
                        end
                        count--;
                        r.ok = 1'b1;
                    end
                    else
                        n_empty_remove++;
                end
                cll_pkg::CMD_SEARCH:
                begin
                    n_search++;
                    cur = head;
                    for (int k = 0; k < count; k++)
                    begin
                        if (node_value[cur] == rq.value)
                        begin
                            r.ok = 1'b1;
                            break;
                        end
                        cur = node_next[cur];
                    end
                    if (r.ok)
                        n_hit++;
                end
                default:
                begin
                    // clear also resets the slot allocator
                    n_clear++;
                    count    = 0;
                    head     = '0;
                    fresh    = 0;
                    free_top = 0;
                    r.ok     = 1'b1;
                end
            endcase
            r.element_total = 8'(count);
            awaited_results.push_back(r);
        endfunction

        // compare one result strobe with the oldest expectation
        function void check_result(cll_pkg::result_t got);
            cll_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                failures++;
                $display("%0t: result with no command outstanding: ok=%0b removed=%0d total=%0d",
                         $time, got.ok, got.removed_value, got.element_total);
                return;
            end
            want = awaited_results.pop_front();
            checked++;
            if (got.ok !== want.ok)
            begin
                failures++;
                $display("%0t: ok mismatch: expected %0b actual %0b",
                         $time, want.ok, got.ok);
            end
            if (got.removed_value !== want.removed_value)
            begin
                failures++;
                $display("%0t: removed_value mismatch: expected %0d actual %0d",
                         $time, want.removed_value, got.removed_value);
            end
            if (got.element_total !== want.element_total)
            begin
                failures++;
                $display("%0t: element_total mismatch: expected %0d actual %0d",
                         $time, want.element_total, got.element_total);
            end
        endfunction
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    cll_pkg::request_t            request;
    logic                         done;
    cll_pkg::result_t             result;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cll_pkg::ADDR_W-1:0]   paddr;
    logic [cll_pkg::DATA_W-1:0]   pwdata;
    logic [cll_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    list_scoreboard               sb;

    circular_list_head_insert_remove_search #(
        .SLOTS(cll_pkg::SLOTS_DEFAULT)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(result);
    end

    // hard stop if the block hangs
    initial
    begin
        #10_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // one command transaction, with an optional idle gap ahead of it
    task automatic send(cll_pkg::cmd_t c, logic [cll_pkg::VALUE_W-1:0] v, int idle_pct);
        cll_pkg::request_t rq;
        int                gap;
        rq.cmd   = c;
        rq.value = v;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(12, 1);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_command(rq);
    endtask

    // drop start and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // apb write of the capacity register
    task automatic write_capacity(logic [cll_pkg::CAP_W-1:0] cap);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= cll_pkg::REG_CAPACITY;
        pwdata  <= cll_pkg::DATA_W'(cap);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        sb.capacity = cap;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // apb read of the capacity register, checked against the shadow
    task automatic read_capacity();
        logic [cll_pkg::DATA_W-1:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= cll_pkg::REG_CAPACITY;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        got = prdata;
        if (got !== cll_pkg::DATA_W'(sb.capacity))
        begin
            sb.failures++;
            $display("%0t: capacity readback mismatch: expected %0d actual %0d",
                     $time, sb.capacity, got);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // random traffic: alternating grow and shrink stretches
    task automatic run_phase(int n_items, int idle_pct, logic [cll_pkg::CAP_W-1:0] cap);
        bit                          grow;
        int                          left;
        int                          roll;
        int                          pick;
        cll_pkg::cmd_t               c;
        logic [cll_pkg::VALUE_W-1:0] v;
        drain();
        write_capacity(cap);
        read_capacity();
        grow = 1'b0;
        left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (left == 0)
            begin
                grow = !grow;
                left = $urandom_range(150, 30);
            end
            left--;
            roll = $urandom_range(99);
            if (roll < 1)
                c = cll_pkg::CMD_CLEAR;
            else if (roll < 23)
                c = cll_pkg::CMD_SEARCH;
            else if (roll < (grow ? 85 : 40))
                c = cll_pkg::CMD_INSERT;
            else
                c = cll_pkg::CMD_REMOVE;
            // small values give duplicates, full-range values toggle every bit
            pick = $urandom_range(99);
            v    = $urandom();
            if (c == cll_pkg::CMD_SEARCH && pick < 50 && sb.count > 0)
                v = sb.stored_value($urandom_range(sb.count - 1));
            else if ((c == cll_pkg::CMD_SEARCH && pick < 75) ||
                     (c == cll_pkg::CMD_INSERT && pick < 40))
                v = cll_pkg::VALUE_W'($urandom_range(8)) - cll_pkg::VALUE_W'(4);
            send(c, v, idle_pct);
        end
    endtask

    initial
    begin
        sb      = new();
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value, then a tiny capacity
        read_capacity();
        write_capacity(8'd3);
        read_capacity();

        // empty list, extremes, full list, slot reuse, clear
        send(cll_pkg::CMD_REMOVE, 32'h1234_5678, 0);
        send(cll_pkg::CMD_SEARCH, 32'd5, 0);
        send(cll_pkg::CMD_INSERT, 32'h8000_0000, 0);
        send(cll_pkg::CMD_INSERT, 32'h7FFF_FFFF, 0);
        send(cll_pkg::CMD_INSERT, 32'h0000_0000, 0);
        send(cll_pkg::CMD_INSERT, 32'hFFFF_FFFF, 0);
        send(cll_pkg::CMD_SEARCH, 32'h8000_0000, 0);
        send(cll_pkg::CMD_SEARCH, 32'h0000_0000, 0);
        send(cll_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 0);
        send(cll_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 0);
        send(cll_pkg::CMD_INSERT, 32'hFFFF_FFFF, 0);
        send(cll_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 0);
        send(cll_pkg::CMD_REMOVE, 32'h0, 0);
        send(cll_pkg::CMD_REMOVE, 32'h0, 0);
        send(cll_pkg::CMD_REMOVE, 32'h0, 0);
        send(cll_pkg::CMD_REMOVE, 32'h0, 0);
        send(cll_pkg::CMD_INSERT, 32'd1, 0);
        send(cll_pkg::CMD_CLEAR, 32'hA5A5_A5A5, 0);
        send(cll_pkg::CMD_SEARCH, 32'd1, 0);
        send(cll_pkg::CMD_INSERT, 32'h5A5A_5A5A, 0);

        // capacity zero refuses every insert
        drain();
        write_capacity(8'd0);
        send(cll_pkg::CMD_INSERT, 32'd7, 0);
        send(cll_pkg::CMD_SEARCH, 32'h5A5A_5A5A, 0);
        send(cll_pkg::CMD_CLEAR, 32'h0, 0);

        // capacity one
        drain();
        write_capacity(8'd1);
        send(cll_pkg::CMD_INSERT, 32'hA5A5_A5A5, 0);
        send(cll_pkg::CMD_INSERT, 32'h0F0F_0F0F, 0);

        // random phases: capacity above the store size saturates
        run_phase(520, 11, 8'd40);
        run_phase(500, 88, 8'd128);
        run_phase(530, 0, 8'd255);

        drain();
        repeat (8) @(posedge clk);

        $display("ran %0d inserts (%0d refused), %0d removes (%0d on an empty list),",
                 sb.n_insert, sb.n_full, sb.n_remove, sb.n_empty_remove);
        $display("%0d searches (%0d found) and %0d clears; %0d results compared",
                 sb.n_search, sb.n_hit, sb.n_clear, sb.checked);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
